// ===== sv/sha256_pkg.sv =====
`timescale 1ns / 1ps

package sha256_pkg;

  localparam logic [1:0] CMD_ABSORB     = 2'd0;
  localparam logic [1:0] CMD_ABSORB_FIN = 2'd1;
  localparam logic [1:0] CMD_FINISH     = 2'd2;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic load;
    logic round;
    logic add;
    logic init;
  } comp_ctrl_t;

  typedef struct packed {
    logic       wr;
    logic [5:0] idx;
    logic [7:0] data;
    logic       shift;
  } sched_ctrl_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== sv/sha256_sched.sv =====
`timescale 1ns / 1ps

module sha256_sched (
  input  logic                    clk_i,
  input  sha256_pkg::sched_ctrl_t ctrl_i,
  output logic [31:0]             w_o
);
  import sha256_pkg::*;

  // Block buffer doubles as the 16-word message schedule window.
  logic [15:0][31:0] words_q;
  logic [31:0]       w_new;
  logic [1:0]        lane;

  assign lane  = ~ctrl_i.idx[1:0];
  assign w_new = small_sigma1(words_q[14]) + words_q[9] + small_sigma0(words_q[1]) +
                 words_q[0];
  assign w_o   = words_q[0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      words_q <= {w_new, words_q[15:1]};
    end else if (ctrl_i.wr) begin
      words_q[ctrl_i.idx[5:2]][{lane, 3'b000} +: 8] <= ctrl_i.data;
    end
  end

endmodule

// ===== sv/sha256_comp.sv =====
`timescale 1ns / 1ps

module sha256_comp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sha256_pkg::comp_ctrl_t ctrl_i,
  input  logic [5:0]             rnd_i,
  input  logic [31:0]            w_i,
  input  logic [2:0]             rd_idx_i,
  output logic [31:0]            rd_word_o
);
  import sha256_pkg::*;

  logic [31:0] hash_q [8];
  logic [31:0] v_q    [8];
  logic [31:0] v_d    [8];
  logic [31:0] t1;
  logic [31:0] t2;

  assign rd_word_o = hash_q[rd_idx_i];

  always_comb begin
    t1 = v_q[7] + big_sigma1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6]) + ROUND_K[rnd_i] + w_i;
    t2 = big_sigma0(v_q[0]) + majority(v_q[0], v_q[1], v_q[2]);
    v_d[7] = v_q[6];
    v_d[6] = v_q[5];
    v_d[5] = v_q[4];
    v_d[4] = v_q[3] + t1;
    v_d[3] = v_q[2];
    v_d[2] = v_q[1];
    v_d[1] = v_q[0];
    v_d[0] = t1 + t2;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      v_q <= hash_q;
    end else if (ctrl_i.round) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HASH_INIT;
    end else if (ctrl_i.init) begin
      hash_q <= HASH_INIT;
    end else if (ctrl_i.add) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= hash_q[i] + v_q[i];
      end
    end
  end

endmodule

// ===== sv/sha256_hash_engine_unit.sv =====
`timescale 1ns / 1ps
// Absorb transaction: takes one byte; one that completes a 64-byte block then runs
// 64 rounds on the shared round unit and 1 chaining add.
// Finish: one pad/fill byte per cycle up to the block end, then the rounds and
// chaining add per padded block, then 8 digest words, one per output transaction.
// Input is stalled in every state but idle, so no byte is taken during the rounds of the single round unit.
// Reset (async, active low) loads the initial hash, clears length and fill.
module sha256_hash_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha256_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_FILL  = 6'b000100,
    S_ROUND = 6'b001000,
    S_ADD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  state_e      nxt_q, nxt_d;
  logic [5:0]  fill_q, fill_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [63:0] bits_q, bits_d;
  logic [2:0]  idx_q, idx_d;
  logic        len_ok_q, len_ok_d;
  logic        in_acc;
  logic        out_acc;
  logic [7:0]  len_byte;
  comp_ctrl_t  comp_ctrl;
  sched_ctrl_t sched_ctrl;
  logic [31:0] w;

  assign in_stall_o    = (state_q != S_IDLE);
  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_valid_o   = (state_q == S_OUT);
  assign out_acc       = out_valid_o && !out_stall_i;
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);
  assign len_byte      = 8'(bits_q >> {~fill_q[2:0], 3'b000});

  always_comb begin
    state_d    = state_q;
    nxt_d      = nxt_q;
    fill_d     = fill_q;
    rnd_d      = rnd_q;
    bits_d     = bits_q;
    idx_d      = idx_q;
    len_ok_d   = len_ok_q;
    comp_ctrl  = '0;
    sched_ctrl = '0;
    sched_ctrl.idx = fill_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (command_i) inside
            CMD_ABSORB, CMD_ABSORB_FIN: begin
              sched_ctrl.wr   = 1'b1;
              sched_ctrl.data = data_byte_i;
              fill_d = fill_q + 6'd1;
              bits_d = bits_q + 64'd8;
              if (fill_q == 6'd63) begin
                comp_ctrl.load = 1'b1;
                rnd_d   = '0;
                state_d = S_ROUND;
                nxt_d   = (command_i == CMD_ABSORB_FIN) ? S_PAD : S_IDLE;
              end else begin
                state_d = (command_i == CMD_ABSORB_FIN) ? S_PAD : S_IDLE;
              end
            end
            CMD_FINISH: state_d = S_PAD;
            default: ;
          endcase
        end
      end
      S_PAD: begin
        sched_ctrl.wr   = 1'b1;
        sched_ctrl.data = PAD_BYTE;
        fill_d   = fill_q + 6'd1;
        len_ok_d = (fill_q < 6'd56) || (fill_q == 6'd63);
        if (fill_q == 6'd63) begin
          comp_ctrl.load = 1'b1;
          rnd_d   = '0;
          state_d = S_ROUND;
          nxt_d   = S_FILL;
        end else begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        sched_ctrl.wr   = 1'b1;
        sched_ctrl.data = ((fill_q[5:3] == 3'b111) && len_ok_q) ? len_byte : 8'h00;
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          comp_ctrl.load = 1'b1;
          rnd_d    = '0;
          state_d  = S_ROUND;
          nxt_d    = len_ok_q ? S_OUT : S_FILL;
          len_ok_d = 1'b1;
        end
      end
      S_ROUND: begin
        comp_ctrl.round  = 1'b1;
        sched_ctrl.shift = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        comp_ctrl.add = 1'b1;
        state_d = nxt_q;
      end
      S_OUT: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            comp_ctrl.init = 1'b1;
            bits_d  = '0;
            fill_d  = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      nxt_q    <= S_IDLE;
      fill_q   <= '0;
      rnd_q    <= '0;
      bits_q   <= '0;
      idx_q    <= '0;
      len_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      nxt_q    <= nxt_d;
      fill_q   <= fill_d;
      rnd_q    <= rnd_d;
      bits_q   <= bits_d;
      idx_q    <= idx_d;
      len_ok_q <= len_ok_d;
    end
  end

  sha256_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_o    (w)
  );

  sha256_comp u_comp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (comp_ctrl),
    .rnd_i     (rnd_q),
    .w_i       (w),
    .rd_idx_i  (idx_q),
    .rd_word_o (digest_word_o)
  );

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while digest pending");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !last_word_o) |=> (out_valid_o && word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest word index did not advance");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_word_o) |=> (!in_stall_o && fill_q == 6'd0 && bits_q == 64'd0))
    else $error("engine not reset after final digest word");

  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && command_i == CMD_FINISH) |=> in_stall_o)
    else $error("finish transaction did not start padding");

endmodule
